// ===== rtl/inactive_fock_builder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Inactive Fock builder assertion macros
// Shared assertion forms used by the interface checker of the block.
// ----------------------------------------------------------------------------
`ifndef INACTIVE_FOCK_BUILDER_TOP_DEFINES_SVH
`define INACTIVE_FOCK_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IFB_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IFB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ifb_pkg.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder package
// Sizes, codes and shared types of the inactive Fock builder.
// ----------------------------------------------------------------------------
package ifb_pkg;

  localparam int unsigned MAX_ORBITALS = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_ORBITALS);
  localparam int unsigned CNT_W        = $clog2(MAX_ORBITALS + 1);
  localparam int unsigned IN_IDX_W     = 4;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CMP_W        = CNT_W + CFG_W;
  localparam int unsigned VAL_W        = 64;
  localparam int unsigned ACC_W        = VAL_W + 12;
  localparam int unsigned ONE_DEPTH    = MAX_ORBITALS ** 2;
  localparam int unsigned TWO_DEPTH    = MAX_ORBITALS ** 4;
  localparam int unsigned ONE_AW       = 2 * IDX_W;
  localparam int unsigned TWO_AW       = 4 * IDX_W;

  localparam logic [CFG_W-1:0] NUM_ORBITALS_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0] NUM_INACTIVE_RST = CFG_W'(0);

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_WR_ONE = 2'd0,
    KIND_WR_TWO = 2'd1,
    KIND_FOCK   = 2'd2,
    KIND_ENERGY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ORBITALS = 1'b0,
    CFG_NUM_INACTIVE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    PH_ONE,
    PH_COUL,
    PH_EXCH
  } phase_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_ADD2,
    OP_SUB
  } acc_op_e;

  typedef struct packed {
    logic              we;
    logic [ONE_AW-1:0] waddr;
    logic [ONE_AW-1:0] raddr;
  } one_req_t;

  typedef struct packed {
    logic              we;
    logic [TWO_AW-1:0] waddr;
    logic [TWO_AW-1:0] raddr;
  } two_req_t;

  typedef struct packed {
    logic    clear;
    logic    valid;
    logic    src_two;
    acc_op_e op;
  } acc_ctrl_t;

  typedef struct packed {
    logic load;
    logic range;
  } done_t;

endpackage

// ===== rtl/ifb_stream_if.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder stream interfaces
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface ifb_in_if;

  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic [ifb_pkg::IN_IDX_W-1:0]         idx_p;
  logic [ifb_pkg::IN_IDX_W-1:0]         idx_q;
  logic [ifb_pkg::IN_IDX_W-1:0]         idx_r;
  logic [ifb_pkg::IN_IDX_W-1:0]         idx_s;
  logic signed [ifb_pkg::VAL_W-1:0]     value;

  modport source (output valid, kind, idx_p, idx_q, idx_r, idx_s, value, input ready);
  modport sink   (input valid, kind, idx_p, idx_q, idx_r, idx_s, value, output ready);

endinterface

interface ifb_out_if;

  logic                             valid;
  logic                             ready;
  logic signed [ifb_pkg::VAL_W-1:0] result_value;
  logic [1:0]                       status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);

endinterface

// ===== rtl/ifb_ram.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ifb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ifb_acc.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder accumulator
// Wide exact accumulator with saturation of the final sum to 64 bits.
// ----------------------------------------------------------------------------
module ifb_acc (
  input  logic                          clk_i,
  input  ifb_pkg::acc_ctrl_t            ctrl_i,
  input  logic [ifb_pkg::VAL_W-1:0]     one_data_i,
  input  logic [ifb_pkg::VAL_W-1:0]     two_data_i,
  output logic [ifb_pkg::VAL_W-1:0]     sum_o,
  output logic                          sat_o
);

  localparam int unsigned EXT_W = ifb_pkg::ACC_W - ifb_pkg::VAL_W;
  localparam int unsigned TOP_W = ifb_pkg::ACC_W - ifb_pkg::VAL_W + 1;

  logic [ifb_pkg::ACC_W-1:0] acc_q;
  logic [ifb_pkg::ACC_W-1:0] acc_d;
  logic [ifb_pkg::VAL_W-1:0] data;
  logic [ifb_pkg::ACC_W-1:0] ext;
  logic [TOP_W-1:0]          top_bits;

  assign data = ctrl_i.src_two ? two_data_i : one_data_i;
  assign ext  = {{EXT_W{data[ifb_pkg::VAL_W-1]}}, data};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.valid) begin
      case (ctrl_i.op)
        ifb_pkg::OP_ADD:  acc_d = acc_q + ext;
        ifb_pkg::OP_ADD2: acc_d = acc_q + {ext[ifb_pkg::ACC_W-2:0], 1'b0};
        ifb_pkg::OP_SUB:  acc_d = acc_q - ext;
        default:          acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign top_bits = acc_q[ifb_pkg::ACC_W-1:ifb_pkg::VAL_W-1];
  assign sat_o    = !((&top_bits) || !(|top_bits));

  always_comb begin
    if (!sat_o) begin
      sum_o = acc_q[ifb_pkg::VAL_W-1:0];
    end else if (acc_q[ifb_pkg::ACC_W-1]) begin
      sum_o = ifb_pkg::VAL_MIN;
    end else begin
      sum_o = ifb_pkg::VAL_MAX;
    end
  end

endmodule

// ===== rtl/ifb_seq.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder sequencer
// Accepts commands, steers store writes and walks the reads of each query.
// ----------------------------------------------------------------------------
module ifb_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  ifb_pkg::kind_e                  kind_i,
  input  logic [ifb_pkg::IN_IDX_W-1:0]    idx_p_i,
  input  logic [ifb_pkg::IN_IDX_W-1:0]    idx_q_i,
  input  logic [ifb_pkg::IN_IDX_W-1:0]    idx_r_i,
  input  logic [ifb_pkg::IN_IDX_W-1:0]    idx_s_i,
  input  logic [ifb_pkg::CNT_W-1:0]       n_eff_i,
  input  logic [ifb_pkg::CNT_W-1:0]       ni_eff_i,
  input  logic                            out_free_i,
  output logic                            in_ready_o,
  output ifb_pkg::one_req_t               one_req_o,
  output ifb_pkg::two_req_t               two_req_o,
  output ifb_pkg::acc_ctrl_t              acc_ctrl_o,
  output ifb_pkg::done_t                  done_o
);

  localparam int unsigned IW = ifb_pkg::IDX_W;
  localparam int unsigned CW = ifb_pkg::CMP_W;

  ifb_pkg::seq_state_e state_q, state_d;
  ifb_pkg::phase_e     phase_q, phase_d;
  logic                energy_q, energy_d;
  logic                range_q, range_d;
  logic [IW-1:0]       pp_q, pp_d;
  logic [IW-1:0]       qq_q, qq_d;
  logic [IW-1:0]       i_q, i_d;
  logic                rd_valid_q;
  logic                rd_two_q;
  ifb_pkg::acc_op_e    rd_op_q;

  logic                accept;
  logic                is_query;
  logic                range_hit;
  logic                ni_zero;
  logic                last_i;
  logic                last_j;
  logic                run_end;
  logic                p_ok, q_ok, r_ok, s_ok;
  logic                issue_valid;
  logic                issue_two;
  ifb_pkg::acc_op_e    issue_op;

  assign accept    = in_valid_i && in_ready_o;
  assign is_query  = (kind_i == ifb_pkg::KIND_FOCK) || (kind_i == ifb_pkg::KIND_ENERGY);
  assign range_hit = (CW'(idx_p_i) >= CW'(n_eff_i)) || (CW'(idx_q_i) >= CW'(n_eff_i));
  assign ni_zero   = (ni_eff_i == '0);
  assign last_i    = (CW'(i_q) + CW'(1)) == CW'(ni_eff_i);
  assign last_j    = (CW'(pp_q) + CW'(1)) == CW'(ni_eff_i);
  assign p_ok      = CW'(idx_p_i) < CW'(ifb_pkg::MAX_ORBITALS);
  assign q_ok      = CW'(idx_q_i) < CW'(ifb_pkg::MAX_ORBITALS);
  assign r_ok      = CW'(idx_r_i) < CW'(ifb_pkg::MAX_ORBITALS);
  assign s_ok      = CW'(idx_s_i) < CW'(ifb_pkg::MAX_ORBITALS);

  always_comb begin
    run_end = 1'b0;
    if (state_q == ifb_pkg::S_RUN) begin
      if (phase_q == ifb_pkg::PH_ONE) begin
        run_end = ni_zero;
      end else if (phase_q == ifb_pkg::PH_EXCH) begin
        run_end = last_i && (!energy_q || last_j);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ifb_pkg::S_IDLE: begin
        if (accept && (kind_i == ifb_pkg::KIND_FOCK)) begin
          state_d = range_hit ? ifb_pkg::S_DONE : ifb_pkg::S_RUN;
        end else if (accept && (kind_i == ifb_pkg::KIND_ENERGY)) begin
          state_d = ni_zero ? ifb_pkg::S_DONE : ifb_pkg::S_RUN;
        end
      end
      ifb_pkg::S_RUN: begin
        if (run_end) begin
          state_d = ifb_pkg::S_WAIT;
        end
      end
      ifb_pkg::S_WAIT: begin
        state_d = ifb_pkg::S_DONE;
      end
      ifb_pkg::S_DONE: begin
        if (out_free_i) begin
          state_d = ifb_pkg::S_IDLE;
        end
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o      = 1'b0;
    done_o          = '0;
    issue_valid     = 1'b0;
    issue_two       = 1'b0;
    issue_op        = ifb_pkg::OP_ADD;
    one_req_o.we    = 1'b0;
    one_req_o.waddr = {IW'(idx_q_i), IW'(idx_p_i)};
    one_req_o.raddr = {qq_q, pp_q};
    two_req_o.we    = 1'b0;
    two_req_o.waddr = {IW'(idx_s_i), IW'(idx_r_i), IW'(idx_q_i), IW'(idx_p_i)};
    two_req_o.raddr = {i_q, i_q, qq_q, pp_q};
    unique case (state_q)
      ifb_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        one_req_o.we = in_valid_i && (kind_i == ifb_pkg::KIND_WR_ONE) && p_ok && q_ok;
        two_req_o.we = in_valid_i && (kind_i == ifb_pkg::KIND_WR_TWO)
                       && p_ok && q_ok && r_ok && s_ok;
      end
      ifb_pkg::S_RUN: begin
        issue_valid = 1'b1;
        case (phase_q)
          ifb_pkg::PH_ONE: begin
            issue_op = energy_q ? ifb_pkg::OP_ADD2 : ifb_pkg::OP_ADD;
          end
          ifb_pkg::PH_COUL: begin
            issue_two = 1'b1;
            issue_op  = ifb_pkg::OP_ADD2;
          end
          ifb_pkg::PH_EXCH: begin
            issue_two       = 1'b1;
            issue_op        = ifb_pkg::OP_SUB;
            two_req_o.raddr = {qq_q, i_q, i_q, pp_q};
          end
          default: begin
            issue_valid = 1'b0;
          end
        endcase
      end
      ifb_pkg::S_WAIT: begin
      end
      ifb_pkg::S_DONE: begin
        done_o.load  = out_free_i;
        done_o.range = range_q;
      end
    endcase
  end

  // Walk counters.
  always_comb begin
    phase_d  = phase_q;
    energy_d = energy_q;
    range_d  = range_q;
    pp_d     = pp_q;
    qq_d     = qq_q;
    i_d      = i_q;
    if (state_q == ifb_pkg::S_IDLE) begin
      if (accept && is_query) begin
        phase_d  = ifb_pkg::PH_ONE;
        i_d      = '0;
        energy_d = (kind_i == ifb_pkg::KIND_ENERGY);
        range_d  = (kind_i == ifb_pkg::KIND_FOCK) && range_hit;
        if (kind_i == ifb_pkg::KIND_ENERGY) begin
          pp_d = '0;
          qq_d = '0;
        end else begin
          pp_d = IW'(idx_p_i);
          qq_d = IW'(idx_q_i);
        end
      end
    end else if (state_q == ifb_pkg::S_RUN) begin
      case (phase_q)
        ifb_pkg::PH_ONE: begin
          phase_d = ifb_pkg::PH_COUL;
          i_d     = '0;
        end
        ifb_pkg::PH_COUL: begin
          phase_d = ifb_pkg::PH_EXCH;
        end
        ifb_pkg::PH_EXCH: begin
          if (!last_i) begin
            i_d     = i_q + IW'(1);
            phase_d = ifb_pkg::PH_COUL;
          end else if (energy_q && !last_j) begin
            pp_d    = pp_q + IW'(1);
            qq_d    = qq_q + IW'(1);
            phase_d = ifb_pkg::PH_ONE;
          end
        end
        default: begin
          phase_d = ifb_pkg::PH_ONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ifb_pkg::S_IDLE;
      phase_q    <= ifb_pkg::PH_ONE;
      energy_q   <= 1'b0;
      range_q    <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      energy_q   <= energy_d;
      range_q    <= range_d;
      rd_valid_q <= issue_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q     <= pp_d;
    qq_q     <= qq_d;
    i_q      <= i_d;
    rd_two_q <= issue_two;
    rd_op_q  <= issue_op;
  end

  assign acc_ctrl_o.clear   = accept && is_query;
  assign acc_ctrl_o.valid   = rd_valid_q;
  assign acc_ctrl_o.src_two = rd_two_q;
  assign acc_ctrl_o.op      = rd_op_q;

endmodule

// ===== rtl/inactive_fock_builder_top.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder
// Top level: configuration registers, T and V stores, sequencer, accumulator.
// ----------------------------------------------------------------------------
// Loads of T(p,q) and V(p,q,r,s) are written straight into a 256-word and a
// 65536-word synchronous memory; the stores have no reset and hold nothing
// until written. A Fock or energy query occupies the block until its result
// is loaded into the output register, and no item is taken meanwhile. The
// single read port of the two-body memory delivers one tensor element per
// cycle into a 76-bit exact accumulator. A finished result sits in an output
// register, so loads continue while it waits to be taken; a following query
// is accepted at once and holds in its last cycle until that register can
// take its result.
module inactive_fock_builder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ifb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ifb_pkg::CFG_W-1:0]       cfg_data_i,
  ifb_in_if.sink                          in_if,
  ifb_out_if.source                       out_if
);

  localparam int unsigned CW = ifb_pkg::CMP_W;

  logic [ifb_pkg::CFG_W-1:0] num_orbitals_q;
  logic [ifb_pkg::CFG_W-1:0] num_inactive_q;
  logic [ifb_pkg::CNT_W-1:0] n_eff;
  logic [ifb_pkg::CNT_W-1:0] ni_eff;

  ifb_pkg::one_req_t         one_req;
  ifb_pkg::two_req_t         two_req;
  ifb_pkg::acc_ctrl_t        acc_ctrl;
  ifb_pkg::done_t            done;
  logic [ifb_pkg::VAL_W-1:0] one_rdata;
  logic [ifb_pkg::VAL_W-1:0] two_rdata;
  logic [ifb_pkg::VAL_W-1:0] acc_sum;
  logic                      acc_sat;

  logic                      out_valid_q;
  logic [ifb_pkg::VAL_W-1:0] out_value_q;
  ifb_pkg::status_e          out_status_q;
  logic                      out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_orbitals_q <= ifb_pkg::NUM_ORBITALS_RST;
      num_inactive_q <= ifb_pkg::NUM_INACTIVE_RST;
    end else if (cfg_we_i) begin
      unique case (ifb_pkg::cfg_reg_e'(cfg_idx_i))
        ifb_pkg::CFG_NUM_ORBITALS: num_orbitals_q <= cfg_data_i;
        ifb_pkg::CFG_NUM_INACTIVE: num_inactive_q <= cfg_data_i;
      endcase
    end
  end

  assign n_eff  = (CW'(num_orbitals_q) > CW'(ifb_pkg::MAX_ORBITALS))
                  ? ifb_pkg::CNT_W'(ifb_pkg::MAX_ORBITALS)
                  : ifb_pkg::CNT_W'(num_orbitals_q);
  assign ni_eff = (CW'(num_inactive_q) > CW'(n_eff))
                  ? n_eff
                  : ifb_pkg::CNT_W'(num_inactive_q);

  assign out_free = !out_valid_q || out_if.ready;

  ifb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .kind_i     (ifb_pkg::kind_e'(in_if.kind)),
    .idx_p_i    (in_if.idx_p),
    .idx_q_i    (in_if.idx_q),
    .idx_r_i    (in_if.idx_r),
    .idx_s_i    (in_if.idx_s),
    .n_eff_i    (n_eff),
    .ni_eff_i   (ni_eff),
    .out_free_i (out_free),
    .in_ready_o (in_if.ready),
    .one_req_o  (one_req),
    .two_req_o  (two_req),
    .acc_ctrl_o (acc_ctrl),
    .done_o     (done)
  );

  ifb_ram #(
    .WIDTH (ifb_pkg::VAL_W),
    .DEPTH (ifb_pkg::ONE_DEPTH)
  ) u_one_ram (
    .clk_i   (clk_i),
    .we_i    (one_req.we),
    .waddr_i (one_req.waddr),
    .wdata_i (in_if.value),
    .raddr_i (one_req.raddr),
    .rdata_o (one_rdata)
  );

  ifb_ram #(
    .WIDTH (ifb_pkg::VAL_W),
    .DEPTH (ifb_pkg::TWO_DEPTH)
  ) u_two_ram (
    .clk_i   (clk_i),
    .we_i    (two_req.we),
    .waddr_i (two_req.waddr),
    .wdata_i (in_if.value),
    .raddr_i (two_req.raddr),
    .rdata_o (two_rdata)
  );

  ifb_acc u_acc (
    .clk_i      (clk_i),
    .ctrl_i     (acc_ctrl),
    .one_data_i (one_rdata),
    .two_data_i (two_rdata),
    .sum_o      (acc_sum),
    .sat_o      (acc_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done.load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.load) begin
      if (done.range) begin
        out_value_q  <= '0;
        out_status_q <= ifb_pkg::ST_RANGE;
      end else begin
        out_value_q  <= acc_sum;
        out_status_q <= acc_sat ? ifb_pkg::ST_SAT : ifb_pkg::ST_OK;
      end
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.result_value = out_value_q;
  assign out_if.status       = out_status_q;

endmodule

// ===== rtl/ifb_checker.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder checker
// Port-level assertions on the result channel and query occupancy.
// ----------------------------------------------------------------------------
`include "inactive_fock_builder_top_defines.svh"

module ifb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [1:0]                  in_kind_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ifb_pkg::VAL_W-1:0]   out_value_i,
  input logic [1:0]                  out_status_i
);

  logic query_transfer;
  logic out_stall;

  assign query_transfer = in_valid_i && in_ready_i
                          && ((in_kind_i == ifb_pkg::KIND_FOCK)
                          || (in_kind_i == ifb_pkg::KIND_ENERGY));
  assign out_stall      = out_valid_i && !out_ready_i;

  `IFB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_value_i), "result changed while stalled")

  `IFB_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_transfer, !in_ready_i, "input taken during a query")

  `IFB_ASSERT_NOW(a_range_zero, clk_i, rst_ni, out_valid_i && (out_status_i == ifb_pkg::ST_RANGE), out_value_i == '0, "range error with non-zero value")

  `IFB_ASSERT_NOW(a_sat_extreme, clk_i, rst_ni, out_valid_i && (out_status_i == ifb_pkg::ST_SAT), (out_value_i == ifb_pkg::VAL_MAX) || (out_value_i == ifb_pkg::VAL_MIN), "saturated value not at an extreme")

endmodule

bind inactive_fock_builder_top ifb_checker u_ifb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .in_kind_i    (in_if.kind),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_value_i  (out_if.result_value),
  .out_status_i (out_if.status)
);

// ===== bench/tb_inactive_fock_builder_top.sv =====
// ----------------------------------------------------------------------------
// Inactive Fock builder testbench
// Loads one-body and two-body elements, then queries Fock elements and the
// inactive energy under a range of register settings. A directed table comes
// first, followed by random load and query traffic with both sides stalling.
// Results are checked against a directed row's own expected value or else an exact 128-bit model.
// ----------------------------------------------------------------------------
module tb_inactive_fock_builder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ifb_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned STALL_LIMIT   = 4000;

  localparam logic signed [VAL_W-1:0] FIX_ONE = 64'sh0000_0100_0000_0000;
  localparam logic signed [127:0]     ACC_HI  = 128'sh7fff_ffff_ffff_ffff;
  localparam logic signed [127:0]     ACC_LO  = {{64{1'b1}}, VAL_MIN};

  typedef struct {
    logic signed [VAL_W-1:0] value;
    status_e                 status;
  } fock_result_t;

  typedef struct {
    bit                      is_cfg;
    logic [CFG_W-1:0]        orbitals;
    logic [CFG_W-1:0]        inactive;
    kind_e                   kind;
    logic [IN_IDX_W-1:0]     p;
    logic [IN_IDX_W-1:0]     q;
    logic [IN_IDX_W-1:0]     r;
    logic [IN_IDX_W-1:0]     s;
    logic signed [VAL_W-1:0] value;
    bit                      typed;
    logic signed [VAL_W-1:0] want_value;
    status_e                 want_status;
  } step_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  ifb_in_if  cmd_ch ();
  ifb_out_if res_ch ();

  inactive_fock_builder_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_if  (cmd_ch),
    .out_if (res_ch)
  );

  // Model of the block: stores, written flags and register copies.
  logic signed [VAL_W-1:0] t_model [ONE_DEPTH];
  logic signed [VAL_W-1:0] v_model [TWO_DEPTH];
  bit                      t_set   [ONE_DEPTH];
  bit                      v_set   [TWO_DEPTH];
  logic [CFG_W-1:0]        orbitals_reg = NUM_ORBITALS_RST;
  logic [CFG_W-1:0]        inactive_reg = NUM_INACTIVE_RST;

  fock_result_t result_q [$];
  step_row_t    directed_rows [$];

  bit          calm = 1'b0;
  int unsigned calm_from = 32'hffff_ffff;
  int unsigned item_limit = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned n_loads = 0;
  int unsigned n_fock = 0;
  int unsigned n_energy = 0;
  int unsigned n_sat = 0;
  int unsigned n_range = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned t_addr(int unsigned p, int unsigned q);
    return p + MAX_ORBITALS * q;
  endfunction

  function automatic int unsigned v_addr(int unsigned p, int unsigned q, int unsigned r,
                                         int unsigned s);
    return p + MAX_ORBITALS * (q + MAX_ORBITALS * (r + MAX_ORBITALS * s));
  endfunction

  function automatic int unsigned eff_orbitals();
    return (orbitals_reg > MAX_ORBITALS) ? MAX_ORBITALS : int'(orbitals_reg);
  endfunction

  function automatic int unsigned eff_inactive();
    return (inactive_reg > eff_orbitals()) ? eff_orbitals() : int'(inactive_reg);
  endfunction

  // Upper bound on the loads needed before an energy query may be sent.
  function automatic int unsigned energy_fill_cost();
    int unsigned cost;
    int unsigned i;
    int unsigned j;
    cost = 0;
    for (i = 0; i < eff_inactive(); i++) begin
      if (!t_set[t_addr(i, i)]) cost++;
      for (j = 0; j < eff_inactive(); j++) begin
        if (!v_set[v_addr(i, i, j, j)]) cost++;
        if (!v_set[v_addr(i, j, j, i)]) cost++;
      end
    end
    return cost;
  endfunction

  function automatic logic signed [127:0] fock_sum(int unsigned p, int unsigned q);
    logic signed [127:0] acc;
    int unsigned         i;
    acc = t_model[t_addr(p, q)];
    for (i = 0; i < eff_inactive(); i++) begin
      acc = acc + 2 * v_model[v_addr(p, q, i, i)] - v_model[v_addr(p, i, i, q)];
    end
    return acc;
  endfunction

  function automatic logic signed [VAL_W-1:0] draw_value();
    logic signed [VAL_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return v;
      default: return v >>> 20;
    endcase
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_W-1:0] orbitals,
                                        logic [CFG_W-1:0] inactive);
    step_row_t row;
    row = '{kind: KIND_WR_ONE, want_status: ST_OK, default: '0};
    row.is_cfg   = 1'b1;
    row.orbitals = orbitals;
    row.inactive = inactive;
    return row;
  endfunction

  function automatic step_row_t load_row(kind_e kind, logic [IN_IDX_W-1:0] p,
                                         logic [IN_IDX_W-1:0] q, logic [IN_IDX_W-1:0] r,
                                         logic [IN_IDX_W-1:0] s,
                                         logic signed [VAL_W-1:0] value);
    step_row_t row;
    row = '{kind: KIND_WR_ONE, want_status: ST_OK, default: '0};
    row.kind  = kind;
    row.p     = p;
    row.q     = q;
    row.r     = r;
    row.s     = s;
    row.value = value;
    return row;
  endfunction

  function automatic step_row_t query_row(kind_e kind, logic [IN_IDX_W-1:0] p,
                                          logic [IN_IDX_W-1:0] q, bit typed,
                                          logic signed [VAL_W-1:0] want_value,
                                          status_e want_status);
    step_row_t row;
    row = '{kind: KIND_WR_ONE, want_status: ST_OK, default: '0};
    row.kind        = kind;
    row.p           = p;
    row.q           = q;
    row.typed       = typed;
    row.want_value  = want_value;
    row.want_status = want_status;
    return row;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Sends one item, waits for its transfer and updates the model.
  task automatic send_cmd(input kind_e kind, input logic [IN_IDX_W-1:0] p,
                          input logic [IN_IDX_W-1:0] q, input logic [IN_IDX_W-1:0] r,
                          input logic [IN_IDX_W-1:0] s,
                          input logic signed [VAL_W-1:0] value,
                          input bit typed = 1'b0,
                          input logic signed [VAL_W-1:0] want_value = '0,
                          input status_e want_status = ST_OK);
    fock_result_t        due;
    logic signed [127:0] acc;
    int unsigned         i;
    if (items_sent >= calm_from) calm = 1'b1;
    if (!calm && $urandom_range(0, 7) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind  <= kind;
    cmd_ch.idx_p <= p;
    cmd_ch.idx_q <= q;
    cmd_ch.idx_r <= r;
    cmd_ch.idx_s <= s;
    cmd_ch.value <= value;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    items_sent++;
    case (kind)
      KIND_WR_ONE: begin
        t_model[t_addr(p, q)] = value;
        t_set[t_addr(p, q)]   = 1'b1;
        n_loads++;
      end
      KIND_WR_TWO: begin
        v_model[v_addr(p, q, r, s)] = value;
        v_set[v_addr(p, q, r, s)]   = 1'b1;
        n_loads++;
      end
      default: begin
        acc = '0;
        if (kind == KIND_FOCK) begin
          n_fock++;
          if (p >= eff_orbitals() || q >= eff_orbitals()) begin
            due.value  = '0;
            due.status = ST_RANGE;
          end else begin
            acc = fock_sum(p, q);
          end
        end else begin
          n_energy++;
          for (i = 0; i < eff_inactive(); i++) begin
            acc = acc + t_model[t_addr(i, i)] + fock_sum(i, i);
          end
        end
        if (kind == KIND_ENERGY || due.status != ST_RANGE || p < eff_orbitals() &&
            q < eff_orbitals()) begin
          if (acc > ACC_HI) begin
            due.value  = VAL_MAX;
            due.status = ST_SAT;
          end else if (acc < ACC_LO) begin
            due.value  = VAL_MIN;
            due.status = ST_SAT;
          end else begin
            due.value  = acc[VAL_W-1:0];
            due.status = ST_OK;
          end
        end
        if (typed) begin
          due.value  = want_value;
          due.status = want_status;
        end
        if (due.status == ST_SAT) n_sat++;
        if (due.status == ST_RANGE) n_range++;
        result_q.push_back(due);
      end
    endcase
  endtask

  // Loads every element that Fi(p,q) reads and that has not been written yet.
  task automatic fill_fock_inputs(input int unsigned p, input int unsigned q);
    int unsigned i;
    if (!t_set[t_addr(p, q)])
      send_cmd(KIND_WR_ONE, p, q, $urandom_range(0, 15), $urandom_range(0, 15), draw_value());
    for (i = 0; i < eff_inactive(); i++) begin
      if (!v_set[v_addr(p, q, i, i)]) send_cmd(KIND_WR_TWO, p, q, i, i, draw_value());
      if (!v_set[v_addr(p, i, i, q)]) send_cmd(KIND_WR_TWO, p, i, i, q, draw_value());
    end
  endtask

  // Registers change only once the block has delivered everything owed.
  task automatic program_regs(input logic [CFG_W-1:0] orbitals,
                              input logic [CFG_W-1:0] inactive);
    cmd_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_NUM_ORBITALS;
    cfg_data_i <= orbitals;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NUM_INACTIVE;
    cfg_data_i <= inactive;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    orbitals_reg  = orbitals;
    inactive_reg  = inactive;
    n_settings++;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] orbitals,
                           input logic [CFG_W-1:0] inactive);
    int unsigned start;
    int unsigned pick;
    int unsigned p;
    int unsigned q;
    int unsigned n;
    int unsigned i;
    program_regs(orbitals, inactive);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS && items_sent < item_limit) begin
      n    = eff_orbitals();
      pick = $urandom_range(0, 19);
      if (pick < 6) begin
        send_cmd(KIND_WR_ONE, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 15), draw_value());
      end else if (pick < 10) begin
        send_cmd(KIND_WR_TWO, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 15), draw_value());
      end else if (pick < 17) begin
        if (n != 0 && $urandom_range(0, 4) != 0) begin
          p = $urandom_range(0, n - 1);
          q = $urandom_range(0, n - 1);
        end else begin
          p = $urandom_range(0, 15);
          q = $urandom_range(0, 15);
        end
        if (p < n && q < n) fill_fock_inputs(p, q);
        send_cmd(KIND_FOCK, p, q, $urandom_range(0, 15), $urandom_range(0, 15),
                 draw_value());
      end else if (energy_fill_cost() <= item_limit - items_sent + PHASE_ITEMS) begin
        for (i = 0; i < eff_inactive(); i++) fill_fock_inputs(i, i);
        send_cmd(KIND_ENERGY, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 15), draw_value());
      end else begin
        send_cmd(KIND_WR_TWO, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 15), draw_value());
      end
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    fock_result_t due;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (result_q.size() == 0) begin
          note_mismatch($sformatf("result %h status %0d with nothing outstanding",
                                  res_ch.result_value, res_ch.status));
        end else begin
          due = result_q.pop_front();
          n_checked++;
          if (res_ch.result_value !== due.value)
            note_mismatch($sformatf("value %h, expected %h", res_ch.result_value,
                                    due.value));
          if (res_ch.status !== due.status)
            note_mismatch($sformatf("status %0d, expected %0d", res_ch.status,
                                    due.status));
        end
      end
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 10);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned      random_start;
    int unsigned      phase;
    logic [CFG_W-1:0] orbitals;
    logic [CFG_W-1:0] inactive;
    cmd_ch.valid = 1'b0;
    cmd_ch.kind  = KIND_WR_ONE;
    cmd_ch.idx_p = '0;
    cmd_ch.idx_q = '0;
    cmd_ch.idx_r = '0;
    cmd_ch.idx_s = '0;
    cmd_ch.value = '0;
    res_ch.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_NUM_ORBITALS;
    cfg_data_i   = '0;

    directed_rows.push_back(load_row(KIND_WR_ONE, 0, 0, 0, 0, VAL_MAX));
    directed_rows.push_back(query_row(KIND_FOCK, 0, 0, 1'b1, VAL_MAX, ST_OK));
    directed_rows.push_back(load_row(KIND_WR_ONE, 15, 15, 15, 15, VAL_MIN));
    directed_rows.push_back(query_row(KIND_FOCK, 15, 15, 1'b1, VAL_MIN, ST_OK));
    directed_rows.push_back(query_row(KIND_ENERGY, 0, 0, 1'b1, '0, ST_OK));
    directed_rows.push_back(cfg_row(4, 0));
    directed_rows.push_back(query_row(KIND_FOCK, 15, 15, 1'b1, '0, ST_RANGE));
    directed_rows.push_back(query_row(KIND_FOCK, 0, 4, 1'b1, '0, ST_RANGE));
    directed_rows.push_back(cfg_row(4, 1));
    directed_rows.push_back(load_row(KIND_WR_TWO, 0, 0, 0, 0, VAL_MAX));
    directed_rows.push_back(query_row(KIND_FOCK, 0, 0, 1'b1, VAL_MAX, ST_SAT));
    directed_rows.push_back(query_row(KIND_ENERGY, 0, 0, 1'b1, VAL_MAX, ST_SAT));
    directed_rows.push_back(load_row(KIND_WR_ONE, 0, 0, 0, 0, VAL_MIN));
    directed_rows.push_back(load_row(KIND_WR_TWO, 0, 0, 0, 0, VAL_MIN));
    directed_rows.push_back(query_row(KIND_FOCK, 0, 0, 1'b1, VAL_MIN, ST_SAT));
    directed_rows.push_back(load_row(KIND_WR_ONE, 0, 0, 0, 0, FIX_ONE));
    directed_rows.push_back(load_row(KIND_WR_TWO, 0, 0, 0, 0, FIX_ONE));
    directed_rows.push_back(load_row(KIND_WR_TWO, 15, 15, 15, 15, -FIX_ONE));
    directed_rows.push_back(query_row(KIND_FOCK, 0, 0, 1'b1, FIX_ONE * 2, ST_OK));
    directed_rows.push_back(query_row(KIND_ENERGY, 0, 0, 1'b1, FIX_ONE * 3, ST_OK));
    directed_rows.push_back(cfg_row(0, 5));
    directed_rows.push_back(query_row(KIND_FOCK, 0, 0, 1'b1, '0, ST_RANGE));
    directed_rows.push_back(query_row(KIND_ENERGY, 0, 0, 1'b1, '0, ST_OK));
    directed_rows.push_back(cfg_row(1, 31));
    directed_rows.push_back(query_row(KIND_ENERGY, 0, 0, 1'b1, FIX_ONE * 3, ST_OK));
    directed_rows.push_back(query_row(KIND_FOCK, 0, 0, 1'b0, '0, ST_OK));
    directed_rows.push_back(cfg_row(31, 0));
    directed_rows.push_back(query_row(KIND_FOCK, 15, 15, 1'b1, VAL_MIN, ST_OK));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) begin
        program_regs(directed_rows[k].orbitals, directed_rows[k].inactive);
      end else begin
        send_cmd(directed_rows[k].kind, directed_rows[k].p, directed_rows[k].q,
                 directed_rows[k].r, directed_rows[k].s, directed_rows[k].value,
                 directed_rows[k].typed, directed_rows[k].want_value,
                 directed_rows[k].want_status);
      end
    end

    random_start = items_sent;
    item_limit   = random_start + RANDOM_ITEMS;
    calm_from    = random_start + RANDOM_ITEMS * 4 / 5;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case (phase)
        0: begin orbitals = 3;  inactive = 2;  end
        1: begin orbitals = 16; inactive = 16; end
        2: begin orbitals = 0;  inactive = 3;  end
        3: begin orbitals = 1;  inactive = 0;  end
        4: begin orbitals = 31; inactive = 31; end
        5: begin orbitals = 9;  inactive = 31; end
        default: begin
          orbitals = $urandom_range(0, 31);
          inactive = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) :
                                                   $urandom_range(0, 5);
        end
      endcase
      run_phase(orbitals, inactive);
      phase++;
    end

    cmd_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results (%0d Fock, %0d energy, %0d saturated, %0d out of range).",
             n_checked, n_fock, n_energy, n_sat, n_range);
    $display("Applied %0d element loads across %0d register settings.", n_loads, n_settings);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ifb_pkg.sv
rtl/ifb_stream_if.sv
rtl/ifb_ram.sv
rtl/ifb_acc.sv
rtl/ifb_seq.sv
rtl/inactive_fock_builder_top.sv
rtl/ifb_checker.sv
bench/tb_inactive_fock_builder_top.sv
